@@ rtl/h3fd_pkg.sv @@
// Shared types and constants of the HTTP/3 frame header deframer.
// No dependencies; used by every module of the block.
`default_nettype none

package h3fd_pkg;

    localparam int VAL_W   = 62;   // QUIC varint value width
    localparam int BYTE_W  = 8;
    localparam int ROLE_W  = 2;
    localparam int CNT_W   = 4;    // varint byte counters
    localparam int TDATA_W = 136;  // byte + kind + length, padded to bytes
    localparam int TUSER_W = 3;    // role + header_done

    // Byte role codes
    localparam logic [ROLE_W-1:0] ROLE_TYPE    = 2'd0;
    localparam logic [ROLE_W-1:0] ROLE_LENGTH  = 2'd1;
    localparam logic [ROLE_W-1:0] ROLE_PAYLOAD = 2'd2;

    // One classified word handed from the front end to the back end
    typedef struct packed {
        logic [BYTE_W-1:0] data_b;
        logic [ROLE_W-1:0] role;
        logic              first_b;   // first byte of a varint field
        logic              hdone;
        logic              fend;
        logic [VAL_W-1:0]  plen;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

@@ rtl/http3_frame_header_deframer_core.sv @@
// HTTP/3 frame header deframer, top level.
// Depends on h3fd_pkg, h3fd_front, h3fd_fifo and h3fd_back.
//
// Usage:
//   Slave stream carries one received byte per word (s_axis_tdata[7:0]).
//   Master stream returns one word per input byte:
//     tdata  [7:0]    byte_out, the input byte
//            [69:8]   frame_kind (zero on type bytes)
//            [131:70] payload_length (zero until the last length byte)
//     tuser  [1:0]    byte_role: 0 type, 1 length, 2 payload
//            [2]      header_done
//     tlast           frame_end, last byte of the frame
//   An accepted byte's word passes through the queue and then the output
//   register; one byte is taken per clock while the output side keeps up.
//   Throughput is set by the front end's per-byte varint/countdown update,
//   a single 62-bit shift-in or decrement plus zero compare per cycle.
//   A FIFO_DEPTH-word queue lets the front end keep accepting while the
//   output is stalled; s_axis_tready drops only once it is full.
//   Synchronous active-low reset returns the parser to the start of a frame
//   type field and empties the queue and output register.
`default_nettype none

module http3_frame_header_deframer_core #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [7:0]    s_axis_tdata,   // [7:0] data_byte
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [135:0]       m_axis_tdata,   // byte_out, frame_kind, payload_length
    output logic [2:0]         m_axis_tuser,   // byte_role, header_done
    output logic               m_axis_tlast    // frame_end
);

    h3fd_pkg::t_entry  front_entry;
    h3fd_pkg::t_entry  q_entry;
    logic              push, pop, q_full, q_empty;

    // Accept whenever the queue has room
    assign s_axis_tready = !q_full;
    assign push          = s_axis_tvalid && s_axis_tready;

    h3fd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (s_axis_tdata),
        .o_entry (front_entry)
    );

    h3fd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_entry (q_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    h3fd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_avail  (!q_empty),
        .i_entry  (q_entry),
        .o_pop    (pop),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/h3fd_front.sv @@
// Front end: classifies each stream byte and decodes the length varint.
// Depends on h3fd_pkg.
`default_nettype none

module h3fd_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire logic [h3fd_pkg::BYTE_W-1:0]  i_data,
    output h3fd_pkg::t_entry                  o_entry
);

    typedef enum logic [1:0] {
        PH_TYPE    = 2'd0,
        PH_LEN     = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    t_phase                          r_phase, n_phase;
    logic [h3fd_pkg::CNT_W-1:0]      r_total, n_total;
    logic [h3fd_pkg::CNT_W-1:0]      r_seen,  n_seen;
    logic [h3fd_pkg::VAL_W-1:0]      r_len,   n_len;
    logic [h3fd_pkg::VAL_W-1:0]      r_rem,   n_rem;

    logic [h3fd_pkg::CNT_W-1:0]      seen_eff, seen_inc, tot;
    logic                            first_b, done;
    logic [h3fd_pkg::VAL_W-1:0]      len_next, rem_dec;

    always_comb begin
        // unused phase code restarts a type field
        seen_eff = (r_phase == PH_TYPE || r_phase == PH_LEN) ? r_seen : '0;
        first_b  = (seen_eff == '0);
        tot      = first_b ? (h3fd_pkg::CNT_W'(1) << i_data[7:6]) : r_total;
        seen_inc = seen_eff + h3fd_pkg::CNT_W'(1);
        done     = (seen_inc >= tot);
        len_next = first_b ? {56'd0, i_data[5:0]} : {r_len[53:0], i_data};
        rem_dec  = r_rem - h3fd_pkg::VAL_W'(1);

        n_phase = r_phase;
        n_total = r_total;
        n_seen  = r_seen;
        n_len   = r_len;
        n_rem   = r_rem;

        o_entry         = '0;
        o_entry.data_b  = i_data;
        o_entry.first_b = first_b;

        case (r_phase)
            PH_LEN: begin
                o_entry.role = h3fd_pkg::ROLE_LENGTH;
                n_total      = tot;
                n_len        = len_next;
                n_seen       = done ? '0 : seen_inc;
                if (done) begin
                    o_entry.hdone = 1'b1;
                    o_entry.plen  = len_next;
                    if (len_next == '0) begin
                        o_entry.fend = 1'b1;
                        n_phase      = PH_TYPE;
                    end else begin
                        n_rem   = len_next;
                        n_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                o_entry.role = h3fd_pkg::ROLE_PAYLOAD;
                o_entry.plen = r_len;
                n_rem        = rem_dec;
                if (rem_dec == '0) begin
                    o_entry.fend = 1'b1;
                    n_phase      = PH_TYPE;
                end
            end
            default: begin
                o_entry.role = h3fd_pkg::ROLE_TYPE;
                n_total      = tot;
                n_seen       = done ? '0 : seen_inc;
                n_phase      = done ? PH_LEN : PH_TYPE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TYPE;
            r_total <= '0;
            r_seen  <= '0;
            r_len   <= '0;
            r_rem   <= '0;
        end else if (i_push) begin
            r_phase <= n_phase;
            r_total <= n_total;
            r_seen  <= n_seen;
            r_len   <= n_len;
            r_rem   <= n_rem;
        end
    end

endmodule

`default_nettype wire

@@ rtl/h3fd_fifo.sv @@
// Short queue of classified words between front and back end.
// Depends on h3fd_pkg.
`default_nettype none

module h3fd_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire h3fd_pkg::t_entry i_entry,
    input  wire logic             i_pop,
    output h3fd_pkg::t_entry      o_entry,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    h3fd_pkg::t_entry   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ rtl/h3fd_back.sv @@
// Back end: decodes the frame type and drives the registered output word.
// Depends on h3fd_pkg.
`default_nettype none

module h3fd_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_avail,
    input  wire h3fd_pkg::t_entry              i_entry,
    output logic                               o_pop,
    input  wire logic                          i_tready,
    output logic                               o_tvalid,
    output logic [h3fd_pkg::TDATA_W-1:0]       o_tdata,
    output logic [h3fd_pkg::TUSER_W-1:0]       o_tuser,
    output logic                               o_tlast
);

    logic                              r_valid;
    logic [h3fd_pkg::VAL_W-1:0]        r_type, n_type;
    logic [h3fd_pkg::TDATA_W-1:0]      r_tdata;
    logic [h3fd_pkg::TUSER_W-1:0]      r_tuser;
    logic                              r_tlast;
    logic [h3fd_pkg::VAL_W-1:0]        kind;

    assign o_pop = i_avail && (!r_valid || i_tready);

    always_comb begin
        n_type = r_type;
        if (i_entry.role == h3fd_pkg::ROLE_TYPE) begin
            n_type = i_entry.first_b ? {56'd0, i_entry.data_b[5:0]}
                                     : {r_type[53:0], i_entry.data_b};
        end
        kind = (i_entry.role == h3fd_pkg::ROLE_TYPE) ? '0 : r_type;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_type  <= '0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_type  <= n_type;
            end else if (i_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_tdata <= {4'd0, i_entry.plen, kind, i_entry.data_b};
            r_tuser <= {i_entry.hdone, i_entry.role};
            r_tlast <= i_entry.fend;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_tdata;
    assign o_tuser  = r_tuser;
    assign o_tlast  = r_tlast;

endmodule

`default_nettype wire
